@@ design/rlrm_pkg.sv @@
package rlrm_pkg;

    localparam int RUN_W     = 32;
    localparam int SECT_W    = 32;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 200;
    localparam int IN_USER_W = 2;
    localparam int OUT_DATA_W = 8;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ON_FAIL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT    = 2'd2;

    typedef struct packed {
        logic [RUN_W-1:0]  start_run;
        logic [RUN_W-1:0]  end_run;
        logic [SECT_W-1:0] start_sect;
        logic [SECT_W-1:0] end_sect;
    } range_entry_t;

    typedef struct packed {
        logic below_start;
        logic past_end;
        logic sect_hit;
    } cmp_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

@@ design/rlrm_range_table.sv @@
module rlrm_range_table #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  rlrm_pkg::range_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output rlrm_pkg::range_entry_t rd_data
);

    rlrm_pkg::range_entry_t mem [DEPTH];
    rlrm_pkg::range_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/rlrm_cmp_unit.sv @@
module rlrm_cmp_unit (
    input  rlrm_pkg::range_entry_t           entry,
    input  logic [rlrm_pkg::RUN_W-1:0]       event_run,
    input  logic [rlrm_pkg::SECT_W-1:0]      event_section,
    output rlrm_pkg::cmp_status_t            status
);

    always_comb
    begin
        status.below_start = event_run < entry.start_run;
        status.past_end    = entry.end_run < event_run;
        status.sect_hit    = (entry.start_sect <= event_section)
                          && (event_section <= entry.end_sect);
    end

endmodule

@@ design/run_lumi_range_mask_core.sv @@
// load transaction: accepted while idle, no result
// check transaction: the SCAN state compares k entries before DONE writes the result, where k is
// the number of table entries compared (at most MAX_RANGES), one per cycle on the read port
// simulation events skip the scan and go from IDLE straight to DONE; no new item is taken before IDLE
// a previous result still waiting on m_tready adds its wait cycles before the next is written
// reset clears control state and config registers; table contents stay undefined until loaded
module run_lumi_range_mask_core #(
    parameter int MAX_RANGES = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // entry_index, first_run, last_run, first_section, last_section,
    // event_run, event_section
    input  logic [rlrm_pkg::IN_DATA_W-1:0]       s_tdata,
    // action, real_data
    input  logic [rlrm_pkg::IN_USER_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // in_mask, keep_event, zero fill
    output logic [rlrm_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [rlrm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlrm_pkg::COUNT_W-1:0]         cfg_wdata
);

    localparam int ADDR_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CNT_W  = $clog2(MAX_RANGES + 1);

    rlrm_pkg::state_t state_reg, state_next;

    logic                              filter_enable_reg;
    logic                              accept_on_fail_reg;
    logic [rlrm_pkg::COUNT_W-1:0]      range_count_reg;

    logic [CNT_W-1:0]                  n_reg, n_next;
    logic [CNT_W-1:0]                  rd_cnt_reg, rd_cnt_next;
    logic                              data_vld_reg, data_vld_next;
    logic                              match_reg, match_next;
    logic [rlrm_pkg::RUN_W-1:0]        event_run_reg, event_run_next;
    logic [rlrm_pkg::SECT_W-1:0]       event_sect_reg, event_sect_next;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic                              in_mask_reg, in_mask_next;
    logic                              keep_reg, keep_next;

    logic                              in_accept;
    logic                              in_action;
    logic                              in_real;
    logic [31:0]                       wr_idx_ext;
    logic [31:0]                       cnt_ext;
    logic [31:0]                       cnt_sat;
    logic                              tbl_wr_en;
    logic                              tbl_rd_en;
    rlrm_pkg::range_entry_t            wr_entry;
    rlrm_pkg::range_entry_t            rd_entry;
    rlrm_pkg::cmp_status_t             cmp;

    assign in_accept = s_tvalid && s_tready;
    assign in_action = s_tuser[0];
    assign in_real   = s_tuser[1];

    assign wr_idx_ext = {24'd0, s_tdata[7:0]};
    assign wr_entry.start_run  = s_tdata[39:8];
    assign wr_entry.end_run    = s_tdata[71:40];
    assign wr_entry.start_sect = s_tdata[103:72];
    assign wr_entry.end_sect   = s_tdata[135:104];

    assign tbl_wr_en = in_accept && (in_action == rlrm_pkg::ACT_LOAD)
                    && (wr_idx_ext < 32'(MAX_RANGES));
    assign tbl_rd_en = (state_reg == rlrm_pkg::ST_SCAN) && (rd_cnt_reg < n_reg);

    assign cnt_ext = {23'd0, range_count_reg};
    assign cnt_sat = (cnt_ext > 32'(MAX_RANGES)) ? 32'(MAX_RANGES) : cnt_ext;

    rlrm_range_table #(
        .DEPTH  (MAX_RANGES),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (wr_idx_ext[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (tbl_rd_en),
        .rd_addr (rd_cnt_reg[ADDR_W-1:0]),
        .rd_data (rd_entry)
    );

    rlrm_cmp_unit u_cmp (
        .entry         (rd_entry),
        .event_run     (event_run_reg),
        .event_section (event_sect_reg),
        .status        (cmp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg  <= 1'b0;
            accept_on_fail_reg <= 1'b0;
            range_count_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rlrm_pkg::CFG_FILTER_ENABLE:  filter_enable_reg  <= cfg_wdata[0];
                rlrm_pkg::CFG_ACCEPT_ON_FAIL: accept_on_fail_reg <= cfg_wdata[0];
                rlrm_pkg::CFG_RANGE_COUNT:    range_count_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= rlrm_pkg::ST_IDLE;
            rd_cnt_reg   <= '0;
            data_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            data_vld_reg <= data_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        match_reg      <= match_next;
        event_run_reg  <= event_run_next;
        event_sect_reg <= event_sect_next;
        in_mask_reg    <= in_mask_next;
        keep_reg       <= keep_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        rd_cnt_next     = rd_cnt_reg;
        data_vld_next   = 1'b0;
        match_next      = match_reg;
        event_run_next  = event_run_reg;
        event_sect_next = event_sect_reg;
        in_mask_next    = in_mask_reg;
        keep_next       = keep_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        s_tready        = 1'b0;

        unique case (state_reg)
            rlrm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (in_action == rlrm_pkg::ACT_CHECK))
                begin
                    event_run_next  = s_tdata[167:136];
                    event_sect_next = s_tdata[199:168];
                    n_next          = cnt_sat[CNT_W-1:0];
                    rd_cnt_next     = '0;
                    match_next      = 1'b0;
                    state_next      = in_real ? rlrm_pkg::ST_SCAN : rlrm_pkg::ST_DONE;
                end
            end
            rlrm_pkg::ST_SCAN:
            begin
                if (tbl_rd_en)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                if (data_vld_reg && cmp.below_start)
                begin
                    match_next = 1'b0;
                    state_next = rlrm_pkg::ST_DONE;
                end
                else if (data_vld_reg && !cmp.past_end && cmp.sect_hit)
                begin
                    match_next = 1'b1;
                    state_next = rlrm_pkg::ST_DONE;
                end
                else if (rd_cnt_reg == n_reg)
                begin
                    match_next = 1'b0;
                    state_next = rlrm_pkg::ST_DONE;
                end
                else
                begin
                    data_vld_next = tbl_rd_en;
                end
            end
            rlrm_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    in_mask_next  = match_reg;
                    keep_next     = filter_enable_reg ? (match_reg ^ accept_on_fail_reg)
                                                      : 1'b1;
                    state_next    = rlrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rlrm_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, keep_reg, in_mask_reg};

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlrm_pkg::ST_SCAN) |-> (rd_cnt_reg <= n_reg))
        else $error("scan read count ran past the entry count");

    a_data_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        data_vld_reg |-> ((state_reg == rlrm_pkg::ST_SCAN) && (rd_cnt_reg != '0)))
        else $error("table data flagged valid without a read");

    a_keep_unfiltered: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !filter_enable_reg) |-> m_tdata[1])
        else $error("event rejected while filtering is off");

    a_keep_filtered: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && filter_enable_reg) |-> (m_tdata[1] == (m_tdata[0] ^ accept_on_fail_reg)))
        else $error("keep decision disagrees with mask result");

endmodule

@@ sim/rlrm_mask_monitor.sv @@
module rlrm_mask_monitor #(
    parameter int MAX_RANGES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rlrm_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [rlrm_pkg::IN_USER_W-1:0]   s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rlrm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [rlrm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rlrm_pkg::COUNT_W-1:0]     cfg_wdata,
    output int                               fail_count,
    output int                               pending_results,
    output int                               hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [rlrm_pkg::SECT_W-1:0]  event_section;
        logic [rlrm_pkg::RUN_W-1:0]   event_run;
        logic [rlrm_pkg::SECT_W-1:0]  last_section;
        logic [rlrm_pkg::SECT_W-1:0]  first_section;
        logic [rlrm_pkg::RUN_W-1:0]   last_run;
        logic [rlrm_pkg::RUN_W-1:0]   first_run;
        logic [rlrm_pkg::INDEX_W-1:0] entry_index;
    } item_fields_t;

    typedef struct packed {
        logic keep_event;
        logic in_mask;
    } mask_result_t;

    rlrm_pkg::range_entry_t        ranges [MAX_RANGES];
    logic                          filter_on;
    logic                          invert_sel;
    logic [rlrm_pkg::COUNT_W-1:0]  scan_limit;
    mask_result_t                  expected_q [$];
    mask_result_t                  want;
    mask_result_t                  got;
    item_fields_t                  item;
    logic                          hit;

    function automatic logic range_hit(logic [rlrm_pkg::RUN_W-1:0] run,
                                       logic [rlrm_pkg::SECT_W-1:0] sect);
        int n;
        n = (int'(scan_limit) > MAX_RANGES) ? MAX_RANGES : int'(scan_limit);
        for (int i = 0; i < n; i++)
        begin
            if (run < ranges[i].start_run)
                return 1'b0;
            if (ranges[i].end_run < run)
                continue;
            if (ranges[i].start_sect <= sect && sect <= ranges[i].end_sect)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_on       = 1'b0;
            invert_sel      = 1'b0;
            scan_limit      = '0;
            expected_q.delete();
            pending_results = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = mask_result_t'(m_tdata[1:0]);
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result transaction: in_mask %0b, keep_event %0b",
                           got.in_mask, got.keep_event);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.in_mask !== want.in_mask)
                    begin
                        $error("in_mask: expected %0b, actual %0b", want.in_mask, got.in_mask);
                        fail_count++;
                    end
                    if (got.keep_event !== want.keep_event)
                    begin
                        $error("keep_event: expected %0b, actual %0b",
                               want.keep_event, got.keep_event);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                item = item_fields_t'(s_tdata);
                if (s_tuser[0] == rlrm_pkg::ACT_LOAD)
                begin
                    if (int'(item.entry_index) < MAX_RANGES)
                    begin
                        ranges[item.entry_index].start_run  = item.first_run;
                        ranges[item.entry_index].end_run    = item.last_run;
                        ranges[item.entry_index].start_sect = item.first_section;
                        ranges[item.entry_index].end_sect   = item.last_section;
                    end
                end
                else
                begin
                    hit = s_tuser[1] ? range_hit(item.event_run, item.event_section) : 1'b0;
                    want.in_mask    = hit;
                    want.keep_event = filter_on ? (hit ^ invert_sel) : 1'b1;
                    expected_q.push_back(want);
                    if (hit)
                        hits_seen++;
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    rlrm_pkg::CFG_FILTER_ENABLE:  filter_on  = cfg_wdata[0];
                    rlrm_pkg::CFG_ACCEPT_ON_FAIL: invert_sel = cfg_wdata[0];
                    rlrm_pkg::CFG_RANGE_COUNT:    scan_limit = cfg_wdata;
                    default: ;
                endcase
            end

            pending_results = expected_q.size();
        end
    end

endmodule

@@ sim/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RANGES  = 256;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 72;
    localparam int END_DRAIN   = MAX_RANGES + 16;
    localparam logic [rlrm_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [rlrm_pkg::IN_DATA_W-1:0]       s_tdata;
    logic [rlrm_pkg::IN_USER_W-1:0]       s_tuser;
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [rlrm_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic                                 cfg_wr_en;
    logic [rlrm_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [rlrm_pkg::COUNT_W-1:0]         cfg_wdata;

    int fail_count;
    int pending_results;
    int hits_seen;
    int gap_pct;
    int stall_pct;
    int cycle_count;
    int loads_sent;
    int checks_sent;
    int scan_span;

    logic [rlrm_pkg::RUN_W-1:0]  tbl_start_run  [MAX_RANGES];
    logic [rlrm_pkg::RUN_W-1:0]  tbl_end_run    [MAX_RANGES];
    logic [rlrm_pkg::SECT_W-1:0] tbl_first_sect [MAX_RANGES];
    logic [rlrm_pkg::SECT_W-1:0] tbl_last_sect  [MAX_RANGES];

    logic phase_filter [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
    logic phase_invert [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    logic [rlrm_pkg::COUNT_W-1:0] phase_count [NUM_PHASES] =
        '{9'd256, 9'd256, 9'd256, 9'd1, 9'd40, 9'd511, 9'd0, 9'd255};

    run_lumi_range_mask_core #(
        .MAX_RANGES(MAX_RANGES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rlrm_mask_monitor #(
        .MAX_RANGES(MAX_RANGES)
    ) u_mask_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .hits_seen       (hits_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] pick_between(logic [31:0] lo, logic [31:0] hi);
        longint unsigned span;
        if (hi < lo)
            return lo;
        span = longint'(hi) - longint'(lo) + 1;
        return lo + 32'(longint'($urandom) % span);
    endfunction

    task automatic send_item(input logic act, input logic real_flag,
                             input logic [rlrm_pkg::IN_DATA_W-1:0] data);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= {real_flag, act};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (act == rlrm_pkg::ACT_LOAD)
            loads_sent++;
        else
            checks_sent++;
    endtask

    task automatic load_range(input logic [rlrm_pkg::INDEX_W-1:0] idx,
                              input logic [rlrm_pkg::RUN_W-1:0] fr,
                              input logic [rlrm_pkg::RUN_W-1:0] lr,
                              input logic [rlrm_pkg::SECT_W-1:0] fs,
                              input logic [rlrm_pkg::SECT_W-1:0] ls);
        tbl_start_run[idx]  = fr;
        tbl_end_run[idx]    = lr;
        tbl_first_sect[idx] = fs;
        tbl_last_sect[idx]  = ls;
        send_item(rlrm_pkg::ACT_LOAD, 1'($urandom),
                  {$urandom, $urandom, ls, fs, lr, fr, idx});
    endtask

    task automatic check_event(input logic [rlrm_pkg::RUN_W-1:0] run,
                               input logic [rlrm_pkg::SECT_W-1:0] sect,
                               input logic real_flag);
        send_item(rlrm_pkg::ACT_CHECK, real_flag,
                  {sect, run, $urandom, $urandom, $urandom, $urandom, 8'($urandom)});
    endtask

    task automatic apply_settings(input logic filt, input logic inv,
                                  input logic [rlrm_pkg::COUNT_W-1:0] count);
        cfg_wr_en <= 1'b1;
        cfg_index <= rlrm_pkg::CFG_FILTER_ENABLE;
        cfg_wdata <= 9'(filt);
        @(negedge clk);
        cfg_index <= rlrm_pkg::CFG_ACCEPT_ON_FAIL;
        cfg_wdata <= 9'(inv);
        @(negedge clk);
        cfg_index <= rlrm_pkg::CFG_RANGE_COUNT;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= 9'($urandom);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        scan_span = (int'(count) > MAX_RANGES) ? MAX_RANGES : int'(count);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_item();
        int pick;
        int slot;
        logic [rlrm_pkg::RUN_W-1:0]  run;
        logic [rlrm_pkg::RUN_W-1:0]  lo;
        logic [rlrm_pkg::RUN_W-1:0]  hi;
        logic [rlrm_pkg::SECT_W-1:0] sect;
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            slot = $urandom_range(0, MAX_RANGES - 1);
            if ($urandom_range(0, 9) == 0)
                load_range(8'(slot), $urandom, $urandom, $urandom, $urandom);
            else
            begin
                // keep the table sorted by start run
                lo   = (slot == 0) ? '0 : tbl_start_run[slot - 1];
                hi   = (slot == MAX_RANGES - 1) ? tbl_start_run[slot] : tbl_start_run[slot + 1];
                run  = (hi >= lo) ? pick_between(lo, hi) : tbl_start_run[slot];
                sect = $urandom_range(0, 300);
                load_range(8'(slot), run, run + $urandom_range(0, 3), sect,
                           sect + $urandom_range(0, 120));
            end
        end
        else if (pick < 30)
            check_event($urandom, $urandom, 1'($urandom));
        else
        begin
            slot = $urandom_range(0, (scan_span > 0) ? scan_span - 1 : MAX_RANGES - 1);
            case ($urandom_range(0, 4))
                0:       run = tbl_start_run[slot] - 1;
                1:       run = tbl_start_run[slot];
                2:       run = tbl_end_run[slot];
                3:       run = tbl_end_run[slot] + 1;
                default: run = pick_between(tbl_start_run[slot], tbl_end_run[slot]);
            endcase
            case ($urandom_range(0, 5))
                0:       sect = tbl_first_sect[slot] - 1;
                1:       sect = tbl_first_sect[slot];
                2:       sect = tbl_last_sect[slot];
                3:       sect = tbl_last_sect[slot] + 1;
                4:       sect = pick_between(tbl_first_sect[slot], tbl_last_sect[slot]);
                default: sect = $urandom_range(0, 500);
            endcase
            check_event(run, sect, $urandom_range(0, 9) != 0);
        end
    endtask

    initial
    begin
        logic [rlrm_pkg::RUN_W-1:0]  base;
        logic [rlrm_pkg::RUN_W-1:0]  run;
        logic [rlrm_pkg::SECT_W-1:0] sect;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        gap_pct   = 0;
        stall_pct = 0;
        scan_span = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: nothing scanned, event always kept
        check_event($urandom, $urandom, 1'b1);
        settle();

        apply_settings(1'b1, 1'b0, 9'(MAX_RANGES));
        base = $urandom_range(1, 1 << 20);
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            run  = base + 3 * i + $urandom_range(0, 2);
            sect = $urandom_range(0, 200);
            load_range(8'(i), run, run + $urandom_range(0, 3), sect,
                       ($urandom_range(0, 15) == 0) ? sect - 1 - $urandom_range(0, 5)
                                                    : sect + $urandom_range(0, 100));
        end

        // top slot at the run limit, section window in the upper half
        load_range(8'(MAX_RANGES - 1), '1, '1, 32'h8000_0000, '1);
        check_event('0, '0, 1'b1);
        check_event('1, '1, 1'b1);
        check_event('1, 32'h8000_0000, 1'b1);
        check_event('1, 32'h7FFF_FFFF, 1'b1);
        check_event('1, '1, 1'b0);
        check_event(tbl_start_run[10], tbl_first_sect[10], 1'b1);
        check_event(tbl_end_run[10], tbl_last_sect[10], 1'b1);
        check_event(tbl_start_run[10], tbl_first_sect[10] - 1, 1'b1);
        check_event(tbl_end_run[10] + 1, tbl_first_sect[10], 1'b1);
        check_event(tbl_start_run[0], tbl_last_sect[0] + 1, 1'b1);
        check_event(tbl_start_run[0], tbl_first_sect[0], 1'b0);
        load_range(8'd0, '0, '0, '0, '0);
        check_event('0, '0, 1'b1);
        check_event('0, 32'd1, 1'b1);
        settle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apply_settings(phase_filter[p], phase_invert[p], phase_count[p]);
            case (idle_mode_t'(p % 4))
                IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
                IDLE_SENDER:   begin gap_pct = 84; stall_pct = 0;  end
                IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 84; end
                default:       begin gap_pct = 21; stall_pct = 21; end
            endcase
            repeat (PHASE_ITEMS) random_item();
            settle();
        end

        repeat (END_DRAIN) @(negedge clk);
        $display("ran %0d table loads and %0d event checks across %0d register settings",
                 loads_sent, checks_sent, NUM_PHASES + 2);
        $display("%0d checks fell inside a range; idle patterns: none, sender, receiver, both",
                 hits_seen);
        if (fail_count == 0 && pending_results == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
